[design/ray_plane_intersect_macros.svh]
// Assertion macros for the ray / plane intersection block.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef RAY_PLANE_INTERSECT_MACROS_SVH
`define RAY_PLANE_INTERSECT_MACROS_SVH

// same-cycle implication
`define RPI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RPI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/rpi_pkg.sv]
`timescale 1ns / 1ps
// Shared constants for the ray / plane intersection block.
// No dependencies.
package rpi_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int EPS_WIDTH       = 32;
	localparam int STATUS_WIDTH    = 2;
	localparam int CFG_IDX_WIDTH   = 3;
	localparam int QUEUE_DEPTH     = 4;

	localparam logic [STATUS_WIDTH-1:0] ST_HIT      = 2'd0;
	localparam logic [STATUS_WIDTH-1:0] ST_PARALLEL = 2'd1;
	localparam logic [STATUS_WIDTH-1:0] ST_BEHIND   = 2'd2;
	localparam logic [STATUS_WIDTH-1:0] ST_HIT_SAT  = 2'd3;

	localparam logic [CFG_IDX_WIDTH-1:0] CFG_PPX = 3'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_PPY = 3'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_PPZ = 3'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_PNX = 3'd3;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_PNY = 3'd4;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_PNZ = 3'd5;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_EPS = 3'd6;

	localparam logic [31:0] NORMAL_Y_RESET = 32'd65536;
	localparam logic [EPS_WIDTH-1:0] EPS_RESET = 32'd4295;

endpackage

[design/rpi_front.sv]
`timescale 1ns / 1ps
// Front end: dot products N.D and (P-O).N, then parallel / behind classification.
// Depends on rpi_pkg.
module rpi_front #(
	parameter int W = rpi_pkg::COORD_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic signed [W-1:0]                  org [3],
	input  logic signed [W-1:0]                  dir [3],
	input  logic signed [W-1:0]                  pp [3],
	input  logic signed [W-1:0]                  pn [3],
	input  logic [rpi_pkg::EPS_WIDTH-1:0]        eps,
	output logic                                 v_s2,
	output logic signed [W-1:0]                  o_s2 [3],
	output logic signed [W-1:0]                  d_s2 [3],
	output logic [2*W-1:0]                       den_mag_s2,
	output logic [2*W:0]                         num_mag_s2,
	output logic [rpi_pkg::STATUS_WIDTH-1:0]     status_s2
);
	import rpi_pkg::*;

	logic                  v_s1;
	logic signed [2*W-1:0] nd_s1 [3];
	logic signed [2*W:0]   pn_s1 [3];
	logic signed [W-1:0]   o_s1 [3];
	logic signed [W-1:0]   d_s1 [3];
	logic signed [W:0]     diff [3];
	logic signed [2*W+1:0] den;
	logic signed [2*W+2:0] num;
	logic [2*W+1:0]        den_abs;
	logic [2*W+2:0]        num_abs;
	logic                  parallel;
	logic                  behind;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = {pp[i][W-1], pp[i]} - {org[i][W-1], org[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				nd_s1[i] <= pn[i] * dir[i];
				pn_s1[i] <= diff[i] * pn[i];
				o_s1[i]  <= org[i];
				d_s1[i]  <= dir[i];
			end
		end
	end

	always_comb begin
		den = (2*W+2)'(nd_s1[0]) + (2*W+2)'(nd_s1[1]) + (2*W+2)'(nd_s1[2]);
		num = (2*W+3)'(pn_s1[0]) + (2*W+3)'(pn_s1[1]) + (2*W+3)'(pn_s1[2]);
		den_abs = den[2*W+1] ? (~den + 1'b1) : den;
		num_abs = num[2*W+2] ? (~num + 1'b1) : num;
		parallel = (den == '0) || (den_abs < (2*W+2)'(eps));
		behind = (num == '0) || (num[2*W+2] != den[2*W+1]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			o_s2       <= o_s1;
			d_s2       <= d_s1;
			den_mag_s2 <= den_abs[2*W-1:0];
			num_mag_s2 <= num_abs[2*W:0];
			if (parallel) begin
				status_s2 <= ST_PARALLEL;
			end else if (behind) begin
				status_s2 <= ST_BEHIND;
			end else begin
				status_s2 <= ST_HIT;
			end
		end
	end

endmodule

[design/rpi_queue.sv]
`timescale 1ns / 1ps
// Short show-ahead queue between front end and back end.
// Depends on rpi_pkg for the default depth.
module rpi_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = rpi_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             nonempty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [AW:0]      cnt_q;

	assign full     = (cnt_q == (AW+1)'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign rdata    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

[design/rpi_back.sv]
`timescale 1ns / 1ps
// Back end: num*D per axis, pipelined restoring divide by den, add origin, saturate.
// Depends on rpi_pkg.
module rpi_back #(
	parameter int W = rpi_pkg::COORD_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic signed [W-1:0]              in_o [3],
	input  logic signed [W-1:0]              in_d [3],
	input  logic [2*W-1:0]                   in_den,
	input  logic [2*W:0]                     in_num,
	input  logic [rpi_pkg::STATUS_WIDTH-1:0] in_status,
	output logic                             pop,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [rpi_pkg::STATUS_WIDTH-1:0] out_status,
	output logic [W-1:0]                     out_hit [3]
);
	import rpi_pkg::*;

	localparam int PW = 3*W;
	localparam int DW = 2*W;

	logic en;
	logic [W-1:0] dm [3];

	logic                    v_s1;
	logic [2*W-1:0]          pl_s1 [3];
	logic [2*W:0]            ph_s1 [3];
	logic signed [W-1:0]     o_s1 [3];
	logic [2:0]              dneg_s1;
	logic [DW-1:0]           den_s1;
	logic [STATUS_WIDTH-1:0] st_s1;

	logic                    v_s2;
	logic [PW-1:0]           prod_s2 [3];
	logic signed [W-1:0]     o_s2 [3];
	logic [2:0]              dneg_s2;
	logic [DW-1:0]           den_s2;
	logic [STATUS_WIDTH-1:0] st_s2;

	logic                    dv_v_s    [0:W];
	logic [PW-1:0]           dv_rem_s  [0:W][3];
	logic [W-1:0]            dv_quo_s  [0:W][3];
	logic [2:0]              dv_big_s  [0:W];
	logic signed [W-1:0]     dv_o_s    [0:W][3];
	logic [2:0]              dv_dneg_s [0:W];
	logic [DW-1:0]           dv_den_s  [0:W];
	logic [STATUS_WIDTH-1:0] dv_st_s   [0:W];

	logic signed [W+1:0] sum [3];
	logic [2:0]          sat;
	logic [W-1:0]        coord [3];
	logic signed [W+1:0] hi_lim;
	logic signed [W+1:0] lo_lim;

	assign en  = !out_valid || out_ready;
	assign pop = en && in_valid;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dm[i] = in_d[i][W-1] ? (~in_d[i] + 1'b1) : in_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pl_s1[i]   <= in_num[W-1:0] * dm[i];
				ph_s1[i]   <= in_num[2*W:W] * dm[i];
				o_s1[i]    <= in_o[i];
				dneg_s1[i] <= in_d[i][W-1];
				prod_s2[i] <= PW'({ph_s1[i], {W{1'b0}}} + {{(W+1){1'b0}}, pl_s1[i]});
			end
			den_s1  <= in_den;
			st_s1   <= in_status;
			o_s2    <= o_s1;
			dneg_s2 <= dneg_s1;
			den_s2  <= den_s1;
			st_s2   <= st_s1;
		end
	end

	for (genvar k = 0; k <= W; k++) begin : g_div
		logic [PW-1:0] rem_n [3];
		logic [W-1:0]  quo_n [3];
		logic [2:0]    big_n;

		if (k == 0) begin : g_first
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					rem_n[i] = prod_s2[i];
					quo_n[i] = '0;
					big_n[i] = prod_s2[i] >= (PW'(den_s2) << W);
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_v_s[k] <= 1'b0;
				end else if (en) begin
					dv_v_s[k] <= v_s2;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					dv_rem_s[k]  <= rem_n;
					dv_quo_s[k]  <= quo_n;
					dv_big_s[k]  <= big_n;
					dv_o_s[k]    <= o_s2;
					dv_dneg_s[k] <= dneg_s2;
					dv_den_s[k]  <= den_s2;
					dv_st_s[k]   <= st_s2;
				end
			end
		end else begin : g_step
			localparam int B = W - k;
			logic [PW-1:0] dsh;

			always_comb begin
				dsh = PW'(dv_den_s[k-1]) << B;
				for (int i = 0; i < 3; i++) begin
					rem_n[i] = dv_rem_s[k-1][i];
					quo_n[i] = dv_quo_s[k-1][i];
					if (dv_rem_s[k-1][i] >= dsh) begin
						rem_n[i]    = dv_rem_s[k-1][i] - dsh;
						quo_n[i][B] = 1'b1;
					end
				end
				big_n = dv_big_s[k-1];
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_v_s[k] <= 1'b0;
				end else if (en) begin
					dv_v_s[k] <= dv_v_s[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					dv_rem_s[k]  <= rem_n;
					dv_quo_s[k]  <= quo_n;
					dv_big_s[k]  <= big_n;
					dv_o_s[k]    <= dv_o_s[k-1];
					dv_dneg_s[k] <= dv_dneg_s[k-1];
					dv_den_s[k]  <= dv_den_s[k-1];
					dv_st_s[k]   <= dv_st_s[k-1];
				end
			end
		end
	end

	always_comb begin
		hi_lim = {3'b000, {(W-1){1'b1}}};
		lo_lim = {3'b111, {(W-1){1'b0}}};
		for (int i = 0; i < 3; i++) begin
			logic [W:0] qc;
			logic signed [W+1:0] oe;
			qc = dv_big_s[W][i] ? {1'b1, {W{1'b0}}} : {1'b0, dv_quo_s[W][i]};
			oe = {{2{dv_o_s[W][i][W-1]}}, dv_o_s[W][i]};
			sum[i] = dv_dneg_s[W][i] ? (oe - {1'b0, qc}) : (oe + {1'b0, qc});
			sat[i] = 1'b0;
			coord[i] = sum[i][W-1:0];
			if (sum[i] > hi_lim) begin
				sat[i]   = 1'b1;
				coord[i] = hi_lim[W-1:0];
			end else if (sum[i] < lo_lim) begin
				sat[i]   = 1'b1;
				coord[i] = lo_lim[W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_v_s[W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dv_st_s[W] == ST_HIT) begin
				out_status <= (sat != 3'b000) ? ST_HIT_SAT : ST_HIT;
				out_hit    <= coord;
			end else begin
				out_status <= dv_st_s[W];
				for (int i = 0; i < 3; i++) begin
					out_hit[i] <= '0;
				end
			end
		end
	end

endmodule

[design/ray_plane_intersect.sv]
`timescale 1ns / 1ps
// Ray / plane intersection: one ray beat in, one result beat out.
// Throughput: one ray per cycle unless the result stream stalls and the internal queue fills,
// which drops s_tready. The back end divides with a one-bit-per-stage quotient pipeline.
// Reset: arst_n clears all handshake state and loads the plane registers with their
// defaults (point 0, normal +y, epsilon 4295).
module ray_plane_intersect #(
	parameter int COORD_WIDTH = rpi_pkg::COORD_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero pad
	input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// hit_x, hit_y, hit_z, zero pad
	output logic [((3*COORD_WIDTH+7)/8)*8-1:0]     m_tdata,
	// hit_status
	output logic [rpi_pkg::STATUS_WIDTH-1:0]       m_tuser,
	input  logic                                   cfg_we,
	input  logic [rpi_pkg::CFG_IDX_WIDTH-1:0]      cfg_idx,
	input  logic [((COORD_WIDTH > 32) ? COORD_WIDTH : 32)-1:0] cfg_wdata
);
	import rpi_pkg::*;

	localparam int W    = COORD_WIDTH;
	localparam int OUTW = ((3*W+7)/8)*8;
	localparam int QW   = 6*W + 2*W + (2*W+1) + STATUS_WIDTH;

	logic signed [W-1:0] pp_q [3];
	logic signed [W-1:0] pn_q [3];
	logic [EPS_WIDTH-1:0] eps_q;

	logic signed [W-1:0] org [3];
	logic signed [W-1:0] dir [3];

	logic                    en_f;
	logic                    v_s2;
	logic signed [W-1:0]     o_s2 [3];
	logic signed [W-1:0]     d_s2 [3];
	logic [2*W-1:0]          den_mag_s2;
	logic [2*W:0]            num_mag_s2;
	logic [STATUS_WIDTH-1:0] status_s2;

	logic          q_push;
	logic          q_pop;
	logic          q_full;
	logic          q_nonempty;
	logic [QW-1:0] q_wdata;
	logic [QW-1:0] q_rdata;

	logic signed [W-1:0]     b_o [3];
	logic signed [W-1:0]     b_d [3];
	logic [2*W-1:0]          b_den;
	logic [2*W:0]            b_num;
	logic [STATUS_WIDTH-1:0] b_status;
	logic [W-1:0]            hit [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pp_q[0] <= '0;
			pp_q[1] <= '0;
			pp_q[2] <= '0;
			pn_q[0] <= '0;
			pn_q[1] <= W'(NORMAL_Y_RESET);
			pn_q[2] <= '0;
			eps_q   <= EPS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_PPX: pp_q[0] <= cfg_wdata[W-1:0];
				CFG_PPY: pp_q[1] <= cfg_wdata[W-1:0];
				CFG_PPZ: pp_q[2] <= cfg_wdata[W-1:0];
				CFG_PNX: pn_q[0] <= cfg_wdata[W-1:0];
				CFG_PNY: pn_q[1] <= cfg_wdata[W-1:0];
				CFG_PNZ: pn_q[2] <= cfg_wdata[W-1:0];
				CFG_EPS: eps_q   <= cfg_wdata[EPS_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			org[i] = s_tdata[i*W +: W];
			dir[i] = s_tdata[(3+i)*W +: W];
		end
	end

	assign en_f     = !(v_s2 && q_full);
	assign s_tready = en_f;
	assign q_push   = v_s2 && !q_full;

	rpi_front #(.W(W)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en_f),
		.in_valid   (s_tvalid),
		.org        (org),
		.dir        (dir),
		.pp         (pp_q),
		.pn         (pn_q),
		.eps        (eps_q),
		.v_s2       (v_s2),
		.o_s2       (o_s2),
		.d_s2       (d_s2),
		.den_mag_s2 (den_mag_s2),
		.num_mag_s2 (num_mag_s2),
		.status_s2  (status_s2)
	);

	assign q_wdata = {status_s2, num_mag_s2, den_mag_s2,
		d_s2[2], d_s2[1], d_s2[0], o_s2[2], o_s2[1], o_s2[0]};

	rpi_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata    (q_wdata),
		.pop      (q_pop),
		.rdata    (q_rdata),
		.full     (q_full),
		.nonempty (q_nonempty)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			b_o[i] = q_rdata[i*W +: W];
			b_d[i] = q_rdata[(3+i)*W +: W];
		end
		b_den    = q_rdata[6*W +: 2*W];
		b_num    = q_rdata[8*W +: 2*W+1];
		b_status = q_rdata[10*W+1 +: STATUS_WIDTH];
	end

	rpi_back #(.W(W)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (q_nonempty),
		.in_o       (b_o),
		.in_d       (b_d),
		.in_den     (b_den),
		.in_num     (b_num),
		.in_status  (b_status),
		.pop        (q_pop),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_status (m_tuser),
		.out_hit    (hit)
	);

	assign m_tdata = OUTW'({hit[2], hit[1], hit[0]});

endmodule

[design/rpi_checker.sv]
`timescale 1ns / 1ps
// Port-level checks on the result stream, bound to ray_plane_intersect.
// Depends on rpi_pkg and ray_plane_intersect_macros.svh.
`include "ray_plane_intersect_macros.svh"

module rpi_checker #(
	parameter int W = rpi_pkg::COORD_WIDTH_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [((3*W+7)/8)*8-1:0]         m_tdata,
	input logic [rpi_pkg::STATUS_WIDTH-1:0] m_tuser
);
	import rpi_pkg::*;

	logic [W-1:0] max_c;
	logic [W-1:0] min_c;
	logic [2:0]   at_bound;
	logic         miss;

	assign max_c = {1'b0, {(W-1){1'b1}}};
	assign min_c = {1'b1, {(W-1){1'b0}}};
	assign miss  = (m_tuser == ST_PARALLEL) || (m_tuser == ST_BEHIND);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			at_bound[i] = (m_tdata[i*W +: W] == max_c) || (m_tdata[i*W +: W] == min_c);
		end
	end

	`RPI_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result beat changed")
	`RPI_ASSERT_IMP(a_miss_zero, m_tvalid && miss, m_tdata[3*W-1:0] == '0, "miss beat carries a nonzero point")
	`RPI_ASSERT_IMP(a_sat_bound, m_tvalid && (m_tuser == ST_HIT_SAT), at_bound != 3'b000, "saturated hit has no coordinate at a bound")

endmodule

bind ray_plane_intersect rpi_checker #(.W(COORD_WIDTH)) u_rpi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
